// ===== rtl/klock_pkg.sv =====
// ----------------------------------------------------------------------------
// klock_pkg: shared types and constants for the key sequence code lock
// Register indexes, trigger mode codes, field widths and the structs passed
// between the configuration block, the evaluator and the top level.
// ----------------------------------------------------------------------------
package klock_pkg;

  localparam int KEY_W       = 5;
  localparam int MASK_W      = 32;
  localparam int MODE_W      = 3;
  localparam int LEN_W       = 4;
  localparam int DIGIT_SLOTS = 8;
  localparam int KEYS_W      = DIGIT_SLOTS * KEY_W;
  localparam int CFG_DATA_W  = KEYS_W;
  localparam int CFG_IDX_W   = 2;

  // Register indexes on the write port.
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_KEYS   = 2'd2;

  // Trigger mode codes.
  localparam logic [MODE_W-1:0] MODE_RESET_ON_ERROR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SIMULTANEOUS   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ORDERED_TOL    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ORDERED_CLEAR  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_RESET_VALUE = MODE_RESET_ON_ERROR;
  localparam logic [LEN_W-1:0]  LEN_RESET_VALUE  = 4'd1;

  typedef struct packed {
    logic [MODE_W-1:0] trigger_mode;
    logic [LEN_W-1:0]  sequence_length;
    logic [KEYS_W-1:0] sequence_keys;
  } cfg_t;

  typedef struct packed {
    logic             matched;
    logic [KEY_W-1:0] announce_key;
    logic             announce_alternate;
    logic             beep;
  } result_t;

endpackage

// ===== rtl/klock_cfg.sv =====
// ----------------------------------------------------------------------------
// klock_cfg: configuration registers
// Holds trigger mode, sequence length and sequence keys; flags a write that
// must restart the progress count.
// ----------------------------------------------------------------------------
module klock_cfg import klock_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg,
  output logic                  progress_clear
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_mode    <= MODE_RESET_VALUE;
      cfg.sequence_length <= LEN_RESET_VALUE;
      cfg.sequence_keys   <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TRIGGER_MODE:    cfg.trigger_mode    <= wr_data[MODE_W-1:0];
        REG_SEQUENCE_LENGTH: cfg.sequence_length <= wr_data[LEN_W-1:0];
        REG_SEQUENCE_KEYS:   cfg.sequence_keys   <= wr_data[KEYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Changing the sequence itself restarts entry.
  assign progress_clear = wr_en && ((wr_index == REG_SEQUENCE_LENGTH) ||
                                    (wr_index == REG_SEQUENCE_KEYS));

endmodule

// ===== rtl/klock_eval.sv =====
// ----------------------------------------------------------------------------
// klock_eval: per-event decision logic
// Compares the pressed key against all sequence digits in parallel and
// produces the result and the next progress count.
// ----------------------------------------------------------------------------
module klock_eval import klock_pkg::*; #(
  parameter int MAX_KEYS = 8
) (
  input  cfg_t                  cfg,
  input  logic [KEY_W-1:0]      key,
  input  logic [MASK_W-1:0]     mask,
  input  logic [$clog2(MAX_KEYS > 1 ? MAX_KEYS : 2)-1:0] progress,
  output logic [$clog2(MAX_KEYS > 1 ? MAX_KEYS : 2)-1:0] progress_next,
  output result_t               result
);

  localparam int PC_W   = $clog2(MAX_KEYS > 1 ? MAX_KEYS : 2);
  localparam int LANES  = 2 ** PC_W;
  localparam int CMP_W  = PC_W + LEN_W + 1;

  logic [KEY_W-1:0] digit [LANES];
  logic [CMP_W-1:0] n_eff;
  logic [LANES-1:0] lane_hit;
  logic [LANES-1:0] lane_set;
  logic             in_seq;
  logic             all_clear;
  logic [PC_W-1:0]  pc;
  logic [CMP_W-1:0] pc_inc;
  logic             hit_cur;
  logic             hit_prev;
  logic             ordered;

  // Effective length: zero counts as one, anything above MAX_KEYS is clamped.
  always_comb begin
    if (cfg.sequence_length == '0) begin
      n_eff = CMP_W'(1);
    end else if (CMP_W'(cfg.sequence_length) > CMP_W'(MAX_KEYS)) begin
      n_eff = CMP_W'(MAX_KEYS);
    end else begin
      n_eff = CMP_W'(cfg.sequence_length);
    end
  end

  // One lane per digit; lanes beyond the stored digits read as zero.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < DIGIT_SLOTS && i < MAX_KEYS) begin : g_held
      assign digit[i] = cfg.sequence_keys[i*KEY_W +: KEY_W];
    end else begin : g_empty
      assign digit[i] = '0;
    end
    assign lane_hit[i] = (CMP_W'(i) < n_eff) && (digit[i] == key);
    assign lane_set[i] = (CMP_W'(i) < n_eff) && (digit[i] != '0) &&
                         mask[digit[i] - KEY_W'(1)];
  end

  assign in_seq    = (key != '0) && (|lane_hit);
  assign all_clear = ~(|lane_set);

  assign pc       = (CMP_W'(progress) >= n_eff) ? '0 : progress;
  assign pc_inc   = CMP_W'(pc) + CMP_W'(1);
  assign hit_cur  = (digit[pc] == key);
  assign hit_prev = (pc != '0) && (digit[pc - PC_W'(1)] == key);
  assign ordered  = (cfg.trigger_mode == MODE_RESET_ON_ERROR) ||
                    (cfg.trigger_mode == MODE_ORDERED_TOL) ||
                    (cfg.trigger_mode == MODE_ORDERED_CLEAR);

  always_comb begin
    result        = '0;
    progress_next = pc;
    if (cfg.trigger_mode == MODE_SIMULTANEOUS) begin
      progress_next = progress;
      if (all_clear) begin
        result.matched = 1'b1;
      end else if (in_seq) begin
        result.announce_key       = key;
        result.announce_alternate = 1'b1;
      end
    end else if (ordered && in_seq) begin
      result.announce_key = key;
      result.beep         = (cfg.trigger_mode != MODE_ORDERED_CLEAR);
      if (hit_cur) begin
        if (pc_inc >= n_eff) begin
          progress_next = '0;
          if ((cfg.trigger_mode != MODE_ORDERED_CLEAR) || all_clear) begin
            result = '0;
            result.matched = 1'b1;
          end
        end else begin
          progress_next = pc_inc[PC_W-1:0];
        end
      end else if (cfg.trigger_mode == MODE_RESET_ON_ERROR) begin
        progress_next = '0;
      end else if ((pc != '0) && !hit_prev) begin
        progress_next = '0;
      end
    end else begin
      progress_next = progress;
    end
  end

endmodule

// ===== rtl/key_sequence_code_lock_top.sv =====
// ----------------------------------------------------------------------------
// key_sequence_code_lock_top: key sequence code lock
// Tracks entry of a configured key sequence and reports matches, key sounds
// and buzzer requests, one result per input event.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  input     in         in_valid / in_stall   key_down, port_state
//  result    out        out_valid / out_stall matched, announce_key,
//                                             announce_alternate, beep
//  config    in         wr_en                 wr_index, wr_data
//
// One event is taken per cycle while in_stall is low. An input transfer loads
// the input register; when the result register advances, the single evaluation
// step writes it from the input register, and the result is offered from
// there.
// rst is synchronous and active high; it clears the valid flags, the progress
// count and loads the configuration reset values.
// When the result side stalls, the input register holds one more event and
// in_stall rises only once both registers are full.
// ----------------------------------------------------------------------------
module key_sequence_code_lock_top import klock_pkg::*; #(
  parameter int MAX_KEYS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KEY_W-1:0]      key_down,
  input  logic [MASK_W-1:0]     port_state,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  matched,
  output logic [KEY_W-1:0]      announce_key,
  output logic                  announce_alternate,
  output logic                  beep,
  // Configuration write port
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  localparam int PC_W = $clog2(MAX_KEYS > 1 ? MAX_KEYS : 2);

  cfg_t             cfg;
  logic             progress_clear;
  logic [PC_W-1:0]  progress;
  logic [PC_W-1:0]  progress_next;
  result_t          eval_result;

  // Input register.
  logic             s1_valid;
  logic [KEY_W-1:0] s1_key;
  logic [MASK_W-1:0] s1_mask;

  logic advance;
  logic in_take;

  klock_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .cfg            (cfg),
    .progress_clear (progress_clear)
  );

  klock_eval #(
    .MAX_KEYS (MAX_KEYS)
  ) u_eval (
    .cfg           (cfg),
    .key           (s1_key),
    .mask          (s1_mask),
    .progress      (progress),
    .progress_next (progress_next),
    .result        (eval_result)
  );

  // The result register moves whenever it is empty or being taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_key  <= key_down;
      s1_mask <= port_state;
    end
  end

  // The progress count steps as the event moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      progress <= '0;
    end else if (progress_clear) begin
      progress <= '0;
    end else if (advance && s1_valid) begin
      progress <= progress_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      matched            <= eval_result.matched;
      announce_key       <= eval_result.announce_key;
      announce_alternate <= eval_result.announce_alternate;
      beep               <= eval_result.beep;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression for the key sequence code lock
// Drives key events with random idle gaps on both channels and programs the
// lock through a run of settings that cover every mode, the length extremes
// and odd codes. It also predicts every result from its own copy of the lock
// state and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module testbench;
  import klock_pkg::*;

  localparam int LOCK_KEYS        = 8;
  localparam int RESULT_LATENCY   = 2;
  localparam int SETTLE_CYCLES    = RESULT_LATENCY + 2;
  localparam int RESET_CYCLES     = 5;
  localparam int RANDOM_PHASES    = 20;
  localparam int EVENTS_PER_PHASE = 55;
  localparam int PRESSURE_PHASE   = 2;
  localparam int HOLD_CYCLES      = 80;
  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int PRINT_LIMIT      = 100;

  // Index with no register behind it, and mode codes the lock does not define.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_UNUSED_LO = 3'd0;
  localparam logic [MODE_W-1:0]    MODE_UNUSED_HI = 3'd7;

  // Short code for the directed part: 5, then 31, then 1.
  localparam logic [KEYS_W-1:0] DEMO_CODE = {25'd0, 5'd1, 5'd31, 5'd5};
  localparam logic [MASK_W-1:0] NO_INPUTS = '0;
  localparam logic [MASK_W-1:0] ALL_INPUTS = '1;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [MASK_W-1:0] mask;
  } key_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [KEY_W-1:0]      key_down = '0;
  logic [MASK_W-1:0]     port_state = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  matched;
  logic [KEY_W-1:0]      announce_key;
  logic                  announce_alternate;
  logic                  beep;
  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;

  key_event_t  pending_events[$];
  result_t     expected_lock_results[$];

  // The lock as the testbench believes it to be.
  logic [MODE_W-1:0] cur_mode;
  logic [LEN_W-1:0]  cur_len;
  logic [KEYS_W-1:0] cur_keys;
  int unsigned       code_progress;

  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned run_left = 0;
  int unsigned hold_left = 0;
  bit          in_xfer = 1'b0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  key_sequence_code_lock_top #(.MAX_KEYS(LOCK_KEYS)) u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .key_down           (key_down),
    .port_state         (port_state),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .matched            (matched),
    .announce_key       (announce_key),
    .announce_alternate (announce_alternate),
    .beep               (beep),
    .wr_en              (wr_en),
    .wr_index           (wr_index),
    .wr_data            (wr_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Lock predictor
  // --------------------------------------------------------------------------

  // Digit i of the code; slots past the eight stored ones read as no key.
  function automatic logic [KEY_W-1:0] code_digit(input int unsigned i);
    if (i >= DIGIT_SLOTS) return '0;
    return cur_keys[KEY_W*i +: KEY_W];
  endfunction

  // A length of zero behaves as one, and anything past the key limit is clipped.
  function automatic int unsigned active_len();
    int unsigned n;
    n = cur_len;
    if (n == 0) n = 1;
    if (n > LOCK_KEYS) n = LOCK_KEYS;
    return n;
  endfunction

  function automatic bit key_in_code(input logic [KEY_W-1:0] key);
    if (key == '0) return 1'b0;
    for (int unsigned i = 0; i < active_len(); i++)
      if (code_digit(i) == key) return 1'b1;
    return 1'b0;
  endfunction

  // True when no input that belongs to a code key is still set in the mask.
  function automatic bit code_inputs_clear(input logic [MASK_W-1:0] mask);
    int unsigned d;
    for (int unsigned i = 0; i < active_len(); i++) begin
      d = code_digit(i);
      if (d != 0 && mask[d-1]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TRIGGER_MODE: begin
        cur_mode = data[MODE_W-1:0];
      end
      REG_SEQUENCE_LENGTH: begin
        cur_len = data[LEN_W-1:0];
        code_progress = 0;
      end
      REG_SEQUENCE_KEYS: begin
        cur_keys = data[KEYS_W-1:0];
        code_progress = 0;
      end
      default: begin
      end
    endcase
  endfunction

  // Works out the result of one key event and advances the progress count.
  function automatic result_t predict_lock_event(input logic [KEY_W-1:0] key,
                                                 input logic [MASK_W-1:0] mask);
    result_t     r;
    int unsigned n;
    bit          done;
    r = '0;
    n = active_len();
    done = 1'b0;
    if (code_progress >= n) code_progress = 0;
    if (cur_mode == MODE_SIMULTANEOUS) begin
      if (code_inputs_clear(mask)) begin
        r.matched = 1'b1;
      end else if (key_in_code(key)) begin
        r.announce_key = key;
        r.announce_alternate = 1'b1;
      end
    end else if ((cur_mode == MODE_RESET_ON_ERROR || cur_mode == MODE_ORDERED_TOL ||
                  cur_mode == MODE_ORDERED_CLEAR) && key_in_code(key)) begin
      if (code_digit(code_progress) == key) begin
        code_progress++;
        if (code_progress >= n) begin
          code_progress = 0;
          if (cur_mode != MODE_ORDERED_CLEAR || code_inputs_clear(mask)) begin
            r.matched = 1'b1;
            done = 1'b1;
          end
        end
      end else if (cur_mode == MODE_RESET_ON_ERROR) begin
        code_progress = 0;
      end else if (code_progress > 0 && code_digit(code_progress - 1) != key) begin
        // A repeat of the last accepted key is tolerated, anything else restarts.
        code_progress = 0;
      end
      if (!done) begin
        r.announce_key = key;
        r.beep = (cur_mode != MODE_ORDERED_CLEAR);
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_data();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  // Masks are biased so that the clear check in modes 2 and 4 goes both ways.
  function automatic logic [MASK_W-1:0] pick_mask();
    logic [MASK_W-1:0] code_bits;
    int unsigned       d;
    code_bits = '0;
    for (int unsigned i = 0; i < active_len(); i++) begin
      d = code_digit(i);
      if (d != 0) code_bits[d-1] = 1'b1;
    end
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return $urandom & ~code_bits;
      4: return ($urandom_range(0, 1) != 0) ? ALL_INPUTS : NO_INPUTS;
      default: return code_bits;
    endcase
  endfunction

  function automatic logic [KEYS_W-1:0] random_code();
    logic [KEYS_W-1:0] code;
    int unsigned       r;
    code = '0;
    for (int unsigned i = 0; i < DIGIT_SLOTS; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0)
        code[KEY_W*i +: KEY_W] = '0;
      else if (r == 1)
        code[KEY_W*i +: KEY_W] = '1;
      else if (r == 2 && i > 0)
        code[KEY_W*i +: KEY_W] = code[KEY_W*$urandom_range(0, i - 1) +: KEY_W];
      else
        code[KEY_W*i +: KEY_W] = KEY_W'($urandom_range(1, 31));
    end
    return code;
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic push_event(input logic [KEY_W-1:0] key, input logic [MASK_W-1:0] mask);
    key_event_t ev;
    ev.key = key;
    ev.mask = mask;
    pending_events.push_back(ev);
  endtask

  // The write lands at the rising edge, where the predictor takes it as well.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    apply_write(idx, data);
    @(negedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Returns once every queued event has been sent and every result is back,
  // and then lets the pipeline settle so it is surely empty before a register write.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_events.size() != 0 || in_valid || expected_lock_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly complete code entries with some noise mixed in: stray keys, repeats,
  // keys out of order and the empty key.
  task automatic queue_random_events(input int unsigned count);
    int unsigned n;
    int unsigned added;
    int unsigned r;
    n = active_len();
    added = 0;
    while (added < count) begin
      r = $urandom_range(0, 9);
      if (r <= 5) begin
        for (int unsigned i = 0; i < n; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            push_event(KEY_W'($urandom), pick_mask());
            added++;
          end
          push_event(code_digit(i), pick_mask());
          added++;
          if ($urandom_range(0, 5) == 0) begin
            push_event(code_digit(i), pick_mask());
            added++;
          end
        end
      end else if (r <= 7) begin
        push_event(code_digit($urandom_range(0, n - 1)), pick_mask());
        added++;
      end else if (r == 8) begin
        push_event(KEY_W'($urandom), pick_mask());
        added++;
      end else begin
        push_event('0, pick_mask());
        added++;
      end
    end
  endtask

  // Early phases step through every mode and through the length extremes; later ones are
  // random, with undefined modes and out-of-range lengths now and then.
  task automatic program_setting(input int unsigned ph);
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  len;
    logic [CFG_DATA_W-1:0] data;
    if (ph < 8)
      mode = MODE_W'(MODE_RESET_ON_ERROR + ph % 4);
    else if ($urandom_range(0, 9) == 0)
      mode = ($urandom_range(0, 1) != 0) ? MODE_UNUSED_LO :
             MODE_W'($urandom_range(MODE_ORDERED_CLEAR + 1, MODE_UNUSED_HI));
    else
      mode = MODE_W'($urandom_range(MODE_RESET_ON_ERROR, MODE_ORDERED_CLEAR));
    if (ph < 8) begin
      case ((ph / 2) % 4)
        0: len = LEN_W'(LOCK_KEYS);
        1: len = LEN_W'(1);
        2: len = '0;
        default: len = '1;
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0: len = '0;
        1: len = LEN_W'($urandom_range(LOCK_KEYS + 1, 15));
        default: len = LEN_W'($urandom_range(1, LOCK_KEYS));
      endcase
    end
    // Unused upper bits of the write data carry noise; only the low bits count.
    data = random_data();
    data[MODE_W-1:0] = mode;
    write_reg(REG_TRIGGER_MODE, data);
    if (ph < 8 || $urandom_range(0, 3) != 0) begin
      data = random_data();
      data[LEN_W-1:0] = len;
      write_reg(REG_SEQUENCE_LENGTH, data);
    end
    if (ph < 8 || $urandom_range(0, 3) != 0)
      write_reg(REG_SEQUENCE_KEYS, random_code());
    if ($urandom_range(0, 5) == 0)
      write_reg(REG_UNUSED, random_data());
  endtask

  // --------------------------------------------------------------------------
  // Event driver: presents queued events at the falling edge. A stalled
  // transfer keeps its payload; a new event only follows an accepted one.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    key_event_t ev;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (in_valid && !in_xfer) begin
      // Still waiting for the lock to take the current event.
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (pending_events.size() != 0) begin
      ev = pending_events.pop_front();
      key_down <= ev.key;
      port_state <= ev.mask;
      in_valid <= 1'b1;
      send_gap = pick_idle();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result stall generator. Random stall and run stretches, and on request
  // one long hold-off so the lock fills up and pushes back on its input.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      out_stall <= 1'b0;
    end else begin
      stall_left = pick_idle();
      run_left = pick_idle();
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge, check a result transfer against the oldest
  // expectation, then predict the result of an input transfer. The watchdog
  // ends the run if no transfer of either kind happens for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      in_xfer = 1'b0;
      idle_cycles = 0;
    end else begin
      in_xfer = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_lock_results.size() == 0) begin
          report_error("result transfer with no event waiting for it");
        end else begin
          want = expected_lock_results.pop_front();
          if (matched !== want.matched)
            report_error($sformatf("matched is %0h, expected %0h", matched, want.matched));
          if (announce_key !== want.announce_key)
            report_error($sformatf("announce_key is %0h, expected %0h",
                                   announce_key, want.announce_key));
          if (announce_alternate !== want.announce_alternate)
            report_error($sformatf("announce_alternate is %0h, expected %0h",
                                   announce_alternate, want.announce_alternate));
          if (beep !== want.beep)
            report_error($sformatf("beep is %0h, expected %0h", beep, want.beep));
        end
      end
      if (in_xfer) expected_lock_results.push_back(predict_lock_event(key_down, port_state));
      if (in_xfer || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    cur_mode = MODE_RESET_VALUE;
    cur_len = LEN_RESET_VALUE;
    cur_keys = '0;
    code_progress = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // After reset the code is all empty digits, so nothing can ever match.
    push_event('0, NO_INPUTS);
    push_event('1, ALL_INPUTS);
    push_event(KEY_W'(1), NO_INPUTS);
    wait_idle();

    // Mode 1: a full entry matches; a wrong key restarts, a stray key is ignored.
    write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(MODE_RESET_ON_ERROR));
    write_reg(REG_SEQUENCE_LENGTH, CFG_DATA_W'(3));
    write_reg(REG_SEQUENCE_KEYS, CFG_DATA_W'(DEMO_CODE));
    push_event(KEY_W'(5), NO_INPUTS);
    push_event(KEY_W'(31), NO_INPUTS);
    push_event(KEY_W'(1), NO_INPUTS);
    push_event(KEY_W'(5), NO_INPUTS);
    push_event(KEY_W'(9), NO_INPUTS);
    push_event(KEY_W'(1), NO_INPUTS);
    push_event('0, ALL_INPUTS);
    wait_idle();

    // Mode 3: pressing the last accepted key again does not lose progress.
    write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(MODE_ORDERED_TOL));
    push_event(KEY_W'(5), NO_INPUTS);
    push_event(KEY_W'(5), NO_INPUTS);
    push_event(KEY_W'(31), NO_INPUTS);
    push_event(KEY_W'(31), NO_INPUTS);
    push_event(KEY_W'(1), NO_INPUTS);
    wait_idle();

    // Mode 4: completing with a code input still set gives no match and no
    // beep; completing with all of them clear matches.
    write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(MODE_ORDERED_CLEAR));
    push_event(KEY_W'(5), NO_INPUTS);
    push_event(KEY_W'(31), NO_INPUTS);
    push_event(KEY_W'(1), MASK_W'(1));
    push_event(KEY_W'(5), NO_INPUTS);
    push_event(KEY_W'(31), NO_INPUTS);
    push_event(KEY_W'(1), NO_INPUTS);
    wait_idle();

    // Mode 2: a code key with inputs set is announced on the alternate set,
    // a stray key is silent, and all inputs clear is a match.
    write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(MODE_SIMULTANEOUS));
    push_event(KEY_W'(31), ALL_INPUTS);
    push_event(KEY_W'(9), ALL_INPUTS);
    push_event('0, NO_INPUTS);
    wait_idle();

    // Undefined modes give an all-zero result; the unused index is ignored.
    write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(MODE_UNUSED_LO));
    push_event(KEY_W'(5), NO_INPUTS);
    wait_idle();
    write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(MODE_UNUSED_HI));
    write_reg(REG_UNUSED, '1);
    push_event(KEY_W'(5), NO_INPUTS);

    // Random phases, one setting each. Some run without any idling, and one
    // holds the result side off while events keep coming.
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      program_setting(ph);
      calm = (ph % 5 == 4) || (ph == PRESSURE_PHASE);
      queue_random_events(EVENTS_PER_PHASE);
      if (ph == PRESSURE_PHASE) hold_req = 1'b1;
    end

    wait_idle();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
